>>> hw/rtl/aeas_pkg.sv
// ----------------------------------------------------------------------------
// aeas_pkg
// Shared widths, constants and the command and status types of the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package aeas_pkg;

   // field widths
   localparam int WORD_W  = 32;
   localparam int TIME_W  = 32;
   localparam int GEAR_W  = 24;
   localparam int TURN_W  = 14;
   localparam int POS_W   = 12;
   localparam int ANGLE_W = 25;
   localparam int SPEED_W = 32;

   // fixed-point scaling
   localparam int ANGLE_FRAC_BITS  = 16;
   localparam int TICKS_PER_SECOND = 1000000;
   localparam int SPEED_SHIFT      = ANGLE_FRAC_BITS - 8;

   // one input turn is 4095 counts, gear is Q8.16: modulus 4095 * 2^16
   localparam int TURN_COUNTS = 4095;
   localparam int GEAR_DIV    = TURN_COUNTS * 65536;
   localparam int GEAR_DIV_W  = 28;
   localparam int HALF_DIV    = GEAR_DIV / 2;
   localparam int FULL_TURN   = 360 * (1 << ANGLE_FRAC_BITS);
   localparam int GEAR_RESET  = 65536;

   // check-bit masks over bits 13..0 of a half word
   localparam logic [13:0] ODD_MASK  = 14'h2AAA;
   localparam logic [13:0] EVEN_MASK = 14'h1555;

   // shared restoring divider
   localparam int DIV_NUM_W = 37;
   localparam int DIV_DEN_W = 32;
   localparam int DIV_CNT_W = 6;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] steps;
      logic [DIV_DEN_W-1:0] rem_init;
      logic [DIV_NUM_W-1:0] num_init;
      logic [DIV_DEN_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_sts_type;

endpackage

`default_nettype wire

>>> hw/rtl/absolute_encoder_angle_speed_core.sv
// ----------------------------------------------------------------------------
// absolute_encoder_angle_speed_core
// Checks a multi-turn encoder reply and returns output-shaft angle and speed.
// ----------------------------------------------------------------------------
// Use:
//   req_* takes one item: the 32-bit encoder reply and the microsecond time of
//   the read. rsp_* returns one item per request: parity flag, turn count,
//   position, shaft angle (degrees, Q.16, 0..360) and speed (deg/s, Q.8).
//   csr_wen/csr_wdata load the signed Q8.16 gear ratio; write it only while
//   the block is idle.
// Timing:
//   One item at a time; the next is taken the cycle after a result moves to
//   the output register. A good reply forms the gear product reduced modulo
//   one output turn (one gear bit a cycle), then the angle quotient and the
//   speed quotient through the shared one-bit-a-cycle divider, with control
//   states between them. With no elapsed time the speed quotient is skipped.
//   A reply failing parity skips the arithmetic and goes straight to output.
// Reset:
//   Gear ratio returns to 1.0; last angle, last time and held speed clear.
// Stall:
//   A result waits in the output register while the next item is accepted and
//   worked on; that item's result holds in the core until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module absolute_encoder_angle_speed_core
   import aeas_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request: [31:0] response_word, [63:32] timestamp_us
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,
   // response: [13:0] turn_count, [25:14] raw_position, [50:26] shaft_angle,
   //           [82:51] shaft_speed, [87:83] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [87:0]      rsp_tdata,
   // response: [0] parity_ok
   output logic             rsp_tuser,
   // gear setting: signed Q8.16 input-to-output ratio
   input  wire logic        csr_wen,
   input  wire logic [23:0] csr_wdata
);

   // sequencer codes
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CHECK  = 4'd1;
   localparam logic [3:0] ST_PREP   = 4'd2;
   localparam logic [3:0] ST_MULT   = 4'd3;
   localparam logic [3:0] ST_SCALE1 = 4'd4;
   localparam logic [3:0] ST_SCALE2 = 4'd5;
   localparam logic [3:0] ST_ADIV   = 4'd6;
   localparam logic [3:0] ST_SPREP1 = 4'd7;
   localparam logic [3:0] ST_SPREP2 = 4'd8;
   localparam logic [3:0] ST_SPREP3 = 4'd9;
   localparam logic [3:0] ST_SDIV   = 4'd10;
   localparam logic [3:0] ST_DONE   = 4'd11;

   localparam int M_W    = TURN_W + 13;              // pos + 4095 * turns
   localparam int T_W    = GEAR_DIV_W + 9;           // remainder * 360
   localparam int N_W    = T_W + ANGLE_FRAC_BITS;    // scaled numerator
   localparam int DIFF_W = ANGLE_W + 1;
   localparam int PROD_W = ANGLE_W + 20;             // |diff| * ticks
   localparam int BIT_CNT_W = 5;

   // check both check bits of one half word
   function automatic logic half_ok(input logic [15:0] h);
      logic odd_exp;
      logic even_exp;
      odd_exp  = ~^(h[13:0] & ODD_MASK);
      even_exp = ~^(h[13:0] & EVEN_MASK);
      return (h[15] == odd_exp) && (h[14] == even_exp);
   endfunction

   logic [3:0]            state_ff, state_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic [TIME_W-1:0]     time_ff, time_in;
   logic [GEAR_W-1:0]     gear_ff, gear_in;
   logic [ANGLE_W-1:0]    prev_angle_ff, prev_angle_in;
   logic [TIME_W-1:0]     prev_time_ff, prev_time_in;
   logic [SPEED_W-1:0]    held_speed_ff, held_speed_in;

   logic                  res_ok_ff, res_ok_in;
   logic [TURN_W-1:0]     res_turn_ff, res_turn_in;
   logic [POS_W-1:0]      res_pos_ff, res_pos_in;
   logic [ANGLE_W-1:0]    res_angle_ff, res_angle_in;
   logic [SPEED_W-1:0]    res_speed_ff, res_speed_in;

   logic [M_W-1:0]        m_ff, m_in;
   logic [GEAR_DIV_W-1:0] term_pos_ff, term_pos_in;
   logic [GEAR_DIV_W-1:0] term_neg_ff, term_neg_in;
   logic                  p_pos_ff, p_pos_in;
   logic [GEAR_W-1:0]     gear_sh_ff, gear_sh_in;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [GEAR_DIV_W-1:0] acc_ff, acc_in;
   logic [T_W-1:0]        t_ff, t_in;
   logic                  r_zero_ff, r_zero_in;
   logic [DIFF_W-1:0]     diff_ff, diff_in;
   logic [TIME_W-1:0]     dt_ff, dt_in;
   logic                  dneg_ff, dneg_in;
   logic [ANGLE_W-1:0]    mag_ff, mag_in;

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [87:0]           rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   div_cmd_type           div_cmd;
   div_sts_type           div_sts;

   logic                  word_ok;
   logic [M_W-1:0]        turn_ext;
   logic [M_W-1:0]        m_calc;
   logic [GEAR_DIV_W:0]   m_wide;
   logic [GEAR_DIV_W:0]   dbl;
   logic [GEAR_DIV_W:0]   red1;
   logic [GEAR_DIV_W-1:0] term_sel;
   logic [GEAR_DIV_W:0]   sum;
   logic [GEAR_DIV_W:0]   red2;
   logic [T_W-1:0]        acc_wide;
   logic [N_W-1:0]        nsum;
   logic [PROD_W-1:0]     prod;
   logic [SPEED_W-1:0]    speed_sat;

   // parity over both halves
   assign word_ok = half_ok(word_ff[31:16]) && half_ok(word_ff[15:0]);

   // pos + 4095 * turns, turns sign-extended
   assign turn_ext = {{(M_W-TURN_W){word_ff[29]}}, word_ff[29:16]};
   assign m_calc   = (turn_ext << 12) - turn_ext + M_W'(word_ff[13:2]);
   assign m_wide   = {{(GEAR_DIV_W+1-M_W){m_ff[M_W-1]}}, m_ff};

   // one gear bit: double mod D, then add the term mod D
   assign dbl      = {acc_ff, 1'b0};
   assign red1     = (dbl >= (GEAR_DIV_W+1)'(GEAR_DIV)) ?
                     dbl - (GEAR_DIV_W+1)'(GEAR_DIV) : dbl;
   assign term_sel = !gear_sh_ff[GEAR_W-1] ? '0 :
                     (bit_cnt_ff == BIT_CNT_W'(GEAR_W-1)) ? term_neg_ff : term_pos_ff;
   assign sum      = {1'b0, red1[GEAR_DIV_W-1:0]} + {1'b0, term_sel};
   assign red2     = (sum >= (GEAR_DIV_W+1)'(GEAR_DIV)) ?
                     sum - (GEAR_DIV_W+1)'(GEAR_DIV) : sum;

   // remainder * 360, then * 2^16 plus half the divisor for rounding
   assign acc_wide = T_W'(acc_ff);
   assign nsum     = {t_ff, {ANGLE_FRAC_BITS{1'b0}}} + N_W'(HALF_DIV);

   // |angle change| * ticks per second
   assign prod     = PROD_W'(mag_ff) * PROD_W'(TICKS_PER_SECOND);

   // clamp the signed quotient to 32 bits
   always_comb begin
      if (dneg_ff) begin
         if (div_sts.quot > DIV_NUM_W'(64'h8000_0000)) begin
            speed_sat = 32'h8000_0000;
         end else begin
            speed_sat = 32'd0 - div_sts.quot[SPEED_W-1:0];
         end
      end else begin
         if (div_sts.quot > DIV_NUM_W'(64'h7FFF_FFFF)) begin
            speed_sat = 32'h7FFF_FFFF;
         end else begin
            speed_sat = div_sts.quot[SPEED_W-1:0];
         end
      end
   end

   // sequencer and datapath next state
   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      time_in       = time_ff;
      gear_in       = csr_wen ? csr_wdata : gear_ff;
      prev_angle_in = prev_angle_ff;
      prev_time_in  = prev_time_ff;
      held_speed_in = held_speed_ff;
      res_ok_in     = res_ok_ff;
      res_turn_in   = res_turn_ff;
      res_pos_in    = res_pos_ff;
      res_angle_in  = res_angle_ff;
      res_speed_in  = res_speed_ff;
      m_in          = m_ff;
      term_pos_in   = term_pos_ff;
      term_neg_in   = term_neg_ff;
      p_pos_in      = p_pos_ff;
      gear_sh_in    = gear_sh_ff;
      bit_cnt_in    = bit_cnt_ff;
      acc_in        = acc_ff;
      t_in          = t_ff;
      r_zero_in     = r_zero_ff;
      diff_in       = diff_ff;
      dt_in         = dt_ff;
      dneg_in       = dneg_ff;
      mag_in        = mag_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      div_cmd       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               word_in  = req_tdata[31:0];
               time_in  = req_tdata[63:32];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (word_ok) begin
               res_ok_in   = 1'b1;
               res_turn_in = word_ff[29:16];
               res_pos_in  = word_ff[13:2];
               m_in        = m_calc;
               state_in    = ST_PREP;
            end else begin
               // bad reply: report the held angle and speed
               res_ok_in    = 1'b0;
               res_turn_in  = '0;
               res_pos_in   = '0;
               res_angle_in = prev_angle_ff;
               res_speed_in = held_speed_ff;
               state_in     = ST_DONE;
            end
         end
         ST_PREP: begin
            // M mod D for the positive bits, -M mod D for the sign bit
            if (m_ff[M_W-1]) begin
               term_pos_in = GEAR_DIV_W'(m_wide + (GEAR_DIV_W+1)'(GEAR_DIV));
               term_neg_in = GEAR_DIV_W'((GEAR_DIV_W+1)'(0) - m_wide);
            end else begin
               term_pos_in = GEAR_DIV_W'(m_wide);
               term_neg_in = (m_ff == '0) ? '0 :
                             GEAR_DIV_W'((GEAR_DIV_W+1)'(GEAR_DIV) - m_wide);
            end
            p_pos_in   = (m_ff != '0) && (gear_ff != '0) &&
                         (m_ff[M_W-1] == gear_ff[GEAR_W-1]);
            gear_sh_in = gear_ff;
            bit_cnt_in = BIT_CNT_W'(GEAR_W-1);
            acc_in     = '0;
            state_in   = ST_MULT;
         end
         ST_MULT: begin
            acc_in     = red2[GEAR_DIV_W-1:0];
            gear_sh_in = {gear_sh_ff[GEAR_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - BIT_CNT_W'(1);
            if (bit_cnt_ff == '0) begin
               state_in = ST_SCALE1;
            end
         end
         ST_SCALE1: begin
            t_in      = (acc_wide << 8) + (acc_wide << 6) + (acc_wide << 5) +
                        (acc_wide << 3);
            r_zero_in = (acc_ff == '0);
            state_in  = ST_SCALE2;
         end
         ST_SCALE2: begin
            div_cmd.start    = 1'b1;
            div_cmd.steps    = DIV_CNT_W'(ANGLE_W);
            div_cmd.rem_init = DIV_DEN_W'(nsum[N_W-1:ANGLE_W]);
            div_cmd.num_init = {nsum[ANGLE_W-1:0], {(DIV_NUM_W-ANGLE_W){1'b0}}};
            div_cmd.divisor  = DIV_DEN_W'(GEAR_DIV);
            state_in         = ST_ADIV;
         end
         ST_ADIV: begin
            if (div_sts.done) begin
               if (r_zero_ff) begin
                  res_angle_in = p_pos_ff ? ANGLE_W'(FULL_TURN) : '0;
               end else begin
                  res_angle_in = div_sts.quot[ANGLE_W-1:0];
               end
               state_in = ST_SPREP1;
            end
         end
         ST_SPREP1: begin
            diff_in  = {1'b0, res_angle_ff} - {1'b0, prev_angle_ff};
            dt_in    = time_ff - prev_time_ff;
            state_in = ST_SPREP2;
         end
         ST_SPREP2: begin
            dneg_in = diff_ff[DIFF_W-1];
            mag_in  = diff_ff[DIFF_W-1] ? ANGLE_W'(DIFF_W'(0) - diff_ff) :
                                          diff_ff[ANGLE_W-1:0];
            if (dt_ff == '0) begin
               // no elapsed time: zero speed, commit now
               res_speed_in  = '0;
               prev_angle_in = res_angle_ff;
               prev_time_in  = time_ff;
               held_speed_in = '0;
               state_in      = ST_DONE;
            end else begin
               state_in = ST_SPREP3;
            end
         end
         ST_SPREP3: begin
            // floor(floor(n / 2^shift) / dt) equals floor(n / (dt * 2^shift))
            div_cmd.start    = 1'b1;
            div_cmd.steps    = DIV_CNT_W'(DIV_NUM_W);
            div_cmd.rem_init = '0;
            div_cmd.num_init = prod[SPEED_SHIFT +: DIV_NUM_W];
            div_cmd.divisor  = dt_ff;
            state_in         = ST_SDIV;
         end
         ST_SDIV: begin
            if (div_sts.done) begin
               res_speed_in  = speed_sat;
               prev_angle_in = res_angle_ff;
               prev_time_in  = time_ff;
               held_speed_in = speed_sat;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            // hand over once the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_user_in   = res_ok_ff;
               rsp_data_in   = {5'b0, res_speed_ff, res_angle_ff, res_pos_ff, res_turn_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         gear_ff       <= GEAR_W'(GEAR_RESET);
         prev_angle_ff <= '0;
         prev_time_ff  <= '0;
         held_speed_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gear_ff       <= gear_in;
         prev_angle_ff <= prev_angle_in;
         prev_time_ff  <= prev_time_in;
         held_speed_ff <= held_speed_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      word_ff      <= word_in;
      time_ff      <= time_in;
      res_ok_ff    <= res_ok_in;
      res_turn_ff  <= res_turn_in;
      res_pos_ff   <= res_pos_in;
      res_angle_ff <= res_angle_in;
      res_speed_ff <= res_speed_in;
      m_ff         <= m_in;
      term_pos_ff  <= term_pos_in;
      term_neg_ff  <= term_neg_in;
      p_pos_ff     <= p_pos_in;
      gear_sh_ff   <= gear_sh_in;
      bit_cnt_ff   <= bit_cnt_in;
      acc_ff       <= acc_in;
      t_ff         <= t_in;
      r_zero_ff    <= r_zero_in;
      diff_ff      <= diff_in;
      dt_ff        <= dt_in;
      dneg_ff      <= dneg_in;
      mag_ff       <= mag_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   // shared divider for the angle and speed quotients
   aeas_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // modular accumulator stays reduced during the gear product
   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULT) |-> acc_ff < GEAR_DIV_W'(GEAR_DIV))
      else $error("gear product accumulator out of range");

   // a bad reply leaves the tracking state alone
   a_bad_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && !word_ok) |=>
         $stable(prev_angle_ff) && $stable(prev_time_ff) && $stable(held_speed_ff))
      else $error("tracking state changed on a bad reply");

   // a delivered angle never exceeds one full turn
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> rsp_data_ff[50:26] <= ANGLE_W'(FULL_TURN))
      else $error("shaft angle above full turn");

endmodule

`default_nettype wire

>>> hw/rtl/aeas_div.sv
// ----------------------------------------------------------------------------
// aeas_div
// Restoring divider, one quotient bit per cycle. The numerator enters as a
// left-aligned shift register under a preset partial remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module aeas_div
   import aeas_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_cmd_type cmd,
   output div_sts_type      sts
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_NUM_W-1:0] quot_ff, quot_in;

   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   trial_sub;
   logic                 fits;

   // shift in the next numerator bit and try the subtract
   assign trial     = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign fits      = trial >= {1'b0, den_ff};

   // next state
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.steps;
         rem_in  = cmd.rem_init;
         den_in  = cmd.divisor;
         num_in  = cmd.num_init;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         num_in  = {num_ff[DIV_NUM_W-2:0], 1'b0};
         quot_in = {quot_ff[DIV_NUM_W-2:0], fits};
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign sts.quot = quot_ff;

   // partial remainder stays below the divisor while iterating
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");

   // a new division never lands on one in flight
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("divider started while busy");

   // done follows the last iteration
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a running division");

endmodule

`default_nettype wire

>>> tb/absolute_encoder_angle_speed_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// absolute_encoder_angle_speed_core_test
// Self-checking bench for the encoder reply decoder, shaft angle and speed.
// Encoder replies go in with bursty valid and come back against a stalling
// ready. A scoreboard keeps its own copy of the gear ratio and the last good
// angle, time and speed. It predicts each reply when the item is taken and
// compares every returned field in order. The gear ratio is reloaded between
// phases, with the extremes among the settings.
// ----------------------------------------------------------------------------

module absolute_encoder_angle_speed_core_test;
   import aeas_pkg::*;

   localparam int          CLOCK_PERIOD = 20;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int          PHASE_ITEMS  = 120;
   localparam int          MAX_PRINTED  = 25;

   // one output turn: 4095 counts times the Q8.16 gear scale
   localparam longint TURN_MOD = longint'(4095) << 16;

   typedef struct {
      logic               ok;
      logic [TURN_W-1:0]  turns;
      logic [POS_W-1:0]   pos;
      logic [ANGLE_W-1:0] angle;
      logic [SPEED_W-1:0] speed;
   } shaft_reading_type;

   // Predict shaft readings and match them against returned items.
   class shaft_reading_board;
      shaft_reading_type  expected_readings[$];
      longint             gear;
      logic [ANGLE_W-1:0] last_angle;
      logic [TIME_W-1:0]  last_stamp;
      logic [SPEED_W-1:0] last_speed;
      int                 errors;

      function new();
         gear       = GEAR_RESET;
         last_angle = '0;
         last_stamp = '0;
         last_speed = '0;
         errors     = 0;
      endfunction

      function void set_gear(logic [GEAR_W-1:0] value);
         gear = $signed(value);
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction

      // inverted odd and even check bits over bits 13..0
      function bit half_good(logic [15:0] h);
         return (h[15] == ~^(h[13:0] & ODD_MASK)) && (h[14] == ~^(h[13:0] & EVEN_MASK));
      endfunction

      // reduce the geared position into one output turn, round half up
      function logic [ANGLE_W-1:0] angle_of(longint turns, longint pos);
         longint          counts;
         longint          product;
         longint          rem;
         longint unsigned scaled;
         counts  = pos + 4095 * turns;
         product = counts * gear;
         rem     = product % TURN_MOD;
         if (rem < 0) begin
            rem += TURN_MOD;
         end
         if (rem == 0) begin
            return (product > 0) ? ANGLE_W'(360 << ANGLE_FRAC_BITS) : '0;
         end
         scaled = longint'(rem) * 360;
         scaled = scaled << ANGLE_FRAC_BITS;
         return ANGLE_W'((scaled + longint'(TURN_MOD / 2)) / longint'(TURN_MOD));
      endfunction

      // angle change over elapsed time, truncated and saturated
      function logic [SPEED_W-1:0] speed_of(logic [ANGLE_W-1:0] angle, logic [TIME_W-1:0] dt);
         longint diff;
         longint num;
         longint den;
         longint quot;
         if (dt == 0) begin
            return '0;
         end
         diff = longint'(angle) - longint'(last_angle);
         num  = diff * TICKS_PER_SECOND;
         den  = longint'(dt) << (ANGLE_FRAC_BITS - 8);
         quot = num / den;
         if (quot > 64'sd2147483647) begin
            quot = 64'sd2147483647;
         end
         if (quot < -64'sd2147483648) begin
            quot = -64'sd2147483648;
         end
         return SPEED_W'(quot);
      endfunction

      // Work out the reply for one taken item and advance the state.
      function void note_request(logic [WORD_W-1:0] word, logic [TIME_W-1:0] stamp);
         shaft_reading_type want;
         longint            turns;
         if (!(half_good(word[31:16]) && half_good(word[15:0]))) begin
            want.ok    = 1'b0;
            want.turns = '0;
            want.pos   = '0;
            want.angle = last_angle;
            want.speed = last_speed;
         end else begin
            turns      = $signed(word[29:16]);
            want.ok    = 1'b1;
            want.turns = word[29:16];
            want.pos   = word[13:2];
            want.angle = angle_of(turns, longint'(word[13:2]));
            want.speed = speed_of(want.angle, stamp - last_stamp);
            last_angle = want.angle;
            last_stamp = stamp;
            last_speed = want.speed;
         end
         expected_readings.push_back(want);
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= MAX_PRINTED) begin
            $display("mismatch at %0t: %s", $realtime, what);
         end
      endtask

      // Compare one returned item with the oldest prediction.
      task check_response(logic tuser, logic [87:0] tdata);
         shaft_reading_type want;
         if (expected_readings.size() == 0) begin
            report_mismatch($sformatf("item with nothing expected, tdata %h", tdata));
            return;
         end
         want = expected_readings.pop_front();
         if (tuser !== want.ok) begin
            report_mismatch($sformatf("parity_ok %b, want %b", tuser, want.ok));
         end
         if (tdata[13:0] !== want.turns) begin
            report_mismatch($sformatf("turn_count %h, want %h", tdata[13:0], want.turns));
         end
         if (tdata[25:14] !== want.pos) begin
            report_mismatch($sformatf("raw_position %h, want %h", tdata[25:14], want.pos));
         end
         if (tdata[50:26] !== want.angle) begin
            report_mismatch($sformatf("shaft_angle %h, want %h", tdata[50:26], want.angle));
         end
         if (tdata[82:51] !== want.speed) begin
            report_mismatch($sformatf("shaft_speed %h, want %h", tdata[82:51], want.speed));
         end
         if (tdata[87:83] !== 5'd0) begin
            report_mismatch($sformatf("padding bits %b, want zero", tdata[87:83]));
         end
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [63:0]       req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [87:0]       rsp_tdata;
   logic              rsp_tuser;
   logic              csr_wen;
   logic [GEAR_W-1:0] csr_wdata;

   shaft_reading_board sb;
   int unsigned        cycle_count;
   int                 stall_hold;
   logic [TIME_W-1:0]  stamp_now;

   absolute_encoder_angle_speed_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
   end

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Build a reply with good check bits in both halves.
   function automatic logic [31:0] encode_reading(logic [13:0] turns, logic [11:0] pos,
                                                  logic [1:0] low);
      logic [13:0] lo;
      lo = {pos, low};
      return {~^(turns & ODD_MASK), ~^(turns & EVEN_MASK), turns,
              ~^(lo & ODD_MASK), ~^(lo & EVEN_MASK), lo};
   endfunction

   // Hold one item until the block takes it, then note it.
   task send_reading(logic [WORD_W-1:0] word, logic [TIME_W-1:0] stamp);
      req_tdata  <= {stamp, word};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sb.note_request(word, stamp);
   endtask

   // Drop valid and hold off until every reply has come back.
   task wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task load_gear(logic [GEAR_W-1:0] value);
      wait_drained();
      csr_wdata <= value;
      csr_wen   <= 1'b1;
      @(posedge clock);
      csr_wen <= 1'b0;
      sb.set_gear(value);
   endtask

   // Random replies in bursts: mostly well formed, some broken, some noise.
   task run_random(int count);
      int          burst_left;
      int          gap;
      int          pick;
      int          sel;
      logic [13:0] turns;
      logic [11:0] pos;
      logic [31:0] word;
      logic [31:0] dt;
      burst_left = $urandom_range(1, 40);
      for (int n = 0; n < count; n++) begin
         // pause between bursts, never after the last item
         if (n != 0 && --burst_left == 0) begin
            sel = $urandom_range(0, 9);
            gap = (sel < 3) ? 0 : (sel < 8) ? $urandom_range(1, 6) : $urandom_range(10, 60);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 40);
         end
         sel = $urandom_range(0, 9);
         case (sel)
            0:       turns = 14'h1FFF;
            1:       turns = 14'h2000;
            2:       turns = 14'($signed($urandom_range(0, 8)) - 4);
            default: turns = 14'($urandom);
         endcase
         sel = $urandom_range(0, 9);
         pos = (sel == 0) ? 12'h000 : (sel == 1) ? 12'hFFF : 12'($urandom);
         word = encode_reading(turns, pos, 2'($urandom));
         pick = $urandom_range(0, 99);
         if (pick >= 90) begin
            word = $urandom;
         end else if (pick >= 80) begin
            word = word ^ (32'd1 << $urandom_range(0, 31));
         end
         sel = $urandom_range(0, 19);
         if (sel == 0) begin
            dt = 0;
         end else if (sel < 3) begin
            dt = $urandom_range(1, 16);
         end else if (sel < 15) begin
            dt = $urandom_range(1, 20000);
         end else if (sel < 17) begin
            dt = $urandom;
         end else begin
            dt = $urandom_range(20000, 2000000);
         end
         stamp_now = stamp_now + dt;
         send_reading(word, stamp_now);
      end
   endtask

   // Return items: always ready, coin toss, long stalls, rare stalls.
   always @(posedge clock) begin
      case (cycle_count[10:9])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 1) == 1);
         2'd2: begin
            if (stall_hold == 0) begin
               rsp_tready <= ~rsp_tready;
               stall_hold <= $urandom_range(1, 40);
            end else begin
               stall_hold <= stall_hold - 1;
            end
         end
         default: rsp_tready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Check every returned item.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tuser, rsp_tdata);
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      logic [31:0] word;
      sb          = new();
      cycle_count = 0;
      stall_hold  = 0;
      stamp_now   = '0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_wen     = 1'b0;
      csr_wdata   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed replies at the reset gear of 1.0
      send_reading(encode_reading(14'h0000, 12'h000, 2'b00), 32'd0);    // no elapsed time
      send_reading(encode_reading(14'h0001, 12'h000, 2'b11), 32'd1000); // exact full turn
      send_reading(encode_reading(14'h3FFF, 12'h000, 2'b01), 32'd2000); // negative full turn
      send_reading(encode_reading(14'h1FFF, 12'hFFF, 2'b10), 32'd2001); // speed clips high
      send_reading(encode_reading(14'h2000, 12'hFFF, 2'b00), 32'd2002); // speed clips low
      send_reading(encode_reading(14'h0000, 12'hFFF, 2'b11), 32'hFFFF_FFF0);
      send_reading(encode_reading(14'h0000, 12'h001, 2'b00), 32'h0000_0005); // time wraps
      send_reading(encode_reading(14'h0000, 12'h800, 2'b01), 32'h0000_0005);
      word = encode_reading(14'h0123, 12'h456, 2'b10);
      send_reading(word ^ 32'h8000_0000, 32'd9);    // upper half odd check bit wrong
      send_reading(word ^ 32'h0000_4000, 32'd10);   // lower half even check bit wrong
      send_reading(word ^ 32'h0001_0000, 32'd11);   // turn bit flipped
      send_reading(32'hFFFF_FFFF, 32'd12);
      send_reading(32'h0000_0000, 32'd13);
      send_reading(encode_reading(14'h1FFF, 12'h000, 2'b00), 32'd14);
      send_reading(encode_reading(14'h2000, 12'h000, 2'b00), 32'd15);
      send_reading(encode_reading(14'h0000, 12'hFFE, 2'b11), 32'd16);
      send_reading(encode_reading(14'h3FFF, 12'hFFF, 2'b11), 32'd17); // zero product
      send_reading(encode_reading(14'h0002, 12'h001, 2'b00), 32'd18);
      stamp_now = 32'd18;

      // random phases across gear settings, extremes first
      run_random(PHASE_ITEMS);
      load_gear(24'h800000);
      run_random(PHASE_ITEMS);
      load_gear(24'h7FFFFF);
      run_random(PHASE_ITEMS / 2);
      wait_drained();
      run_random(PHASE_ITEMS / 2);
      load_gear(24'h000000);
      run_random(PHASE_ITEMS);
      load_gear(24'h000001);
      run_random(PHASE_ITEMS);
      load_gear(24'hFFFFFF);
      run_random(PHASE_ITEMS);
      load_gear(24'h030000);
      run_random(PHASE_ITEMS);
      load_gear(24'hFF0000);
      run_random(PHASE_ITEMS);
      load_gear(24'($urandom));
      run_random(PHASE_ITEMS);
      load_gear(24'($urandom));
      run_random(PHASE_ITEMS);

      // drain, then watch for stray items
      wait_drained();
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
